@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define RSL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RSL_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rsl_pkg.sv @@
`timescale 1ns / 1ps

package rsl_pkg;

  localparam int LEN_W   = 16;
  localparam int PHASE_W = 4;

  localparam logic [LEN_W-1:0] MAX_TOKEN_LEN = 16'hFFFF;
  localparam logic [7:0]       MAX_DEPTH     = 8'd255;
  localparam logic [7:0]       MAX_POUNDS    = 8'd255;

  // Commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_CHAR    = 2'd1;
  localparam logic [1:0] CMD_EOF     = 2'd2;
  localparam logic [1:0] CMD_RESTORE = 2'd3;

  // Token kinds
  localparam logic [2:0] KIND_RAWSTART   = 3'd0;
  localparam logic [2:0] KIND_RAWCONTENT = 3'd1;
  localparam logic [2:0] KIND_RAWEND     = 3'd2;
  localparam logic [2:0] KIND_COMMENT    = 3'd3;
  localparam logic [2:0] KIND_INNERDOC   = 3'd4;
  localparam logic [2:0] KIND_OUTERDOC   = 3'd5;

  // Scan phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DISPATCH  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RS_POUNDS = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RC_SCAN   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_RC_CLOSE  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_RE_EAT    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CO_AFTER2 = 4'd7;
  localparam logic [PHASE_W-1:0] PH_CM_LOOP   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_CM_SLASH  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_CM_STAR   = 4'd10;

  // Characters
  localparam logic [7:0] CH_POUND = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_ASCII_MAX = 8'd127;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] valid_mask;
    logic [7:0] ch;
    logic [7:0] restore_pounds;
  } item_t;

  typedef struct packed {
    logic             accepted;
    logic [2:0]       token_kind;
    logic [LEN_W-1:0] token_length;
    logic [7:0]       pound_count_out;
  } result_t;

  // Saturating length count
  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    sat_inc = (v == MAX_TOKEN_LEN) ? v : v + {{(LEN_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

@@ hdl/rsl_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsl_core import rsl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output logic    res_fire,
  output result_t res
);

  logic [PHASE_W-1:0] scan_phase, scan_phase_next;
  logic [5:0]         kind_mask, kind_mask_next;
  logic [7:0]         stored_pounds, stored_pounds_next;
  logic [7:0]         running_pounds, running_pounds_next;
  logic [7:0]         depth, depth_next;
  logic [LEN_W-1:0]   consumed, consumed_next;
  logic [LEN_W-1:0]   marked_len, marked_len_next;
  logic               marked, marked_next;

  logic [PHASE_W-1:0] ph;
  logic               eof, done, fin, fin_ok, blank;
  logic [2:0]         fin_kind;
  logic [7:0]         c;
  logic [8:0]         rp_sum;

  assign c     = item.ch;
  assign eof   = (item.cmd == CMD_EOF);
  assign blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign rp_sum = {1'b0, running_pounds} + 9'd1;

  // One item: resolve the chained phases, then the phase that consumes or decides
  always_comb begin
    scan_phase_next     = scan_phase;
    kind_mask_next      = kind_mask;
    stored_pounds_next  = stored_pounds;
    running_pounds_next = running_pounds;
    depth_next          = depth;
    consumed_next       = consumed;
    marked_len_next     = marked_len;
    marked_next         = marked;
    ph       = scan_phase;
    done     = 1'b0;
    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_kind = KIND_RAWSTART;

    case (item.cmd)
      CMD_START: begin
        kind_mask_next      = item.valid_mask;
        running_pounds_next = '0;
        depth_next          = '0;
        consumed_next       = '0;
        marked_len_next     = '0;
        marked_next         = 1'b0;
        scan_phase_next     = PH_FIRST;
      end
      CMD_RESTORE: begin
        stored_pounds_next = item.restore_pounds;
      end
      default: begin
        if (scan_phase != PH_IDLE) begin
          // first character: comment path has precedence
          if (ph == PH_FIRST) begin
            if (|kind_mask[5:3]) begin
              done = 1'b1;
              if (eof) begin
                fin = 1'b1;
              end else if (kind_mask[4] && c == CH_BANG) begin
                consumed_next = sat_inc(consumed_next);
                fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_INNERDOC;
              end else if (kind_mask[5] && c == CH_STAR) begin
                consumed_next   = sat_inc(consumed_next);
                marked_len_next = consumed_next;
                marked_next     = 1'b1;
                scan_phase_next = PH_CO_AFTER2;
              end else begin
                consumed_next   = sat_inc(consumed_next);
                depth_next      = 8'd1;
                scan_phase_next = PH_CM_LOOP;
              end
            end else begin
              scan_phase_next = PH_DISPATCH;
              if (!eof && blank) done = 1'b1;
              else ph = PH_DISPATCH;
            end
          end

          // raw path selection
          if (!done && ph == PH_DISPATCH) begin
            if (eof) begin
              done = 1'b1; fin = 1'b1;
            end else if (kind_mask[0] && c == CH_R) begin
              done = 1'b1;
              consumed_next       = sat_inc(consumed_next);
              running_pounds_next = '0;
              scan_phase_next     = PH_RS_POUNDS;
            end else if (kind_mask[1]) begin
              ph = PH_RC_SCAN;
            end else if (kind_mask[2] && c == CH_QUOTE) begin
              done = 1'b1;
              consumed_next       = sat_inc(consumed_next);
              running_pounds_next = '0;
              if (stored_pounds_next == 8'd0) begin
                fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_RAWEND;
              end else begin
                scan_phase_next = PH_RE_EAT;
              end
            end else begin
              done = 1'b1; fin = 1'b1;
            end
          end

          // pounds after a content quote
          if (!done && ph == PH_RC_CLOSE) begin
            if (eof) begin
              done = 1'b1; fin = 1'b1;
            end else if (running_pounds < stored_pounds && c == CH_POUND) begin
              done = 1'b1;
              running_pounds_next = rp_sum[7:0];
              consumed_next       = sat_inc(consumed_next);
              if (rp_sum[7:0] == stored_pounds) begin
                fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_RAWCONTENT;
              end
            end else begin
              ph = PH_RC_SCAN;
            end
          end

          // outer doc check
          if (!done && ph == PH_CO_AFTER2) begin
            if (!eof && c == CH_SLASH) begin
              done = 1'b1; fin = 1'b1;
            end else if (!eof && c == CH_STAR) begin
              depth_next = 8'd1;
              ph = PH_CM_LOOP;
            end else begin
              done = 1'b1; fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_OUTERDOC;
            end
          end

          // possible nested opener
          if (!done && ph == PH_CM_SLASH) begin
            if (eof) begin
              done = 1'b1; fin = 1'b1;
            end else if (c == CH_STAR && depth >= MAX_DEPTH) begin
              done = 1'b1; fin = 1'b1;
            end else begin
              if (c == CH_STAR) depth_next = depth + 8'd1;
              ph = PH_CM_LOOP;
            end
          end

          // possible closer
          if (!done && ph == PH_CM_STAR) begin
            if (eof) begin
              done = 1'b1; fin = 1'b1;
            end else begin
              if (c == CH_SLASH && depth != 8'd0) begin
                depth_next = depth - 8'd1;
                if (depth == 8'd1) begin
                  done = 1'b1; fin = 1'b1;
                  fin_ok = kind_mask[3]; fin_kind = KIND_COMMENT;
                end
              end
              if (!done) ph = PH_CM_LOOP;
            end
          end

          // phases that always consume or decide
          if (!done) begin
            case (ph)
              PH_RS_POUNDS: begin
                if (eof) begin
                  fin = 1'b1;
                end else if (c == CH_POUND) begin
                  if (running_pounds >= MAX_POUNDS) begin
                    fin = 1'b1;
                  end else begin
                    running_pounds_next = rp_sum[7:0];
                    consumed_next       = sat_inc(consumed_next);
                  end
                end else if (c == CH_QUOTE) begin
                  consumed_next      = sat_inc(consumed_next);
                  stored_pounds_next = running_pounds;
                  fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_RAWSTART;
                end else begin
                  fin = 1'b1;
                end
              end
              PH_RC_SCAN: begin
                if (eof) begin
                  fin = 1'b1;
                end else if (c == CH_QUOTE) begin
                  marked_len_next     = consumed_next;
                  marked_next         = 1'b1;
                  consumed_next       = sat_inc(consumed_next);
                  running_pounds_next = '0;
                  if (stored_pounds == 8'd0) begin
                    fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_RAWCONTENT;
                  end else begin
                    scan_phase_next = PH_RC_CLOSE;
                  end
                end else begin
                  consumed_next   = sat_inc(consumed_next);
                  scan_phase_next = PH_RC_SCAN;
                end
              end
              PH_RE_EAT: begin
                if (eof) begin
                  fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_RAWEND;
                end else begin
                  consumed_next       = sat_inc(consumed_next);
                  running_pounds_next = rp_sum[7:0];
                  if (rp_sum >= {1'b0, stored_pounds}) begin
                    fin = 1'b1; fin_ok = 1'b1; fin_kind = KIND_RAWEND;
                  end
                end
              end
              PH_CM_LOOP: begin
                if (eof) begin
                  fin = 1'b1;
                end else if (c == CH_SLASH) begin
                  consumed_next   = sat_inc(consumed_next);
                  scan_phase_next = PH_CM_SLASH;
                end else if (c == CH_STAR) begin
                  if (depth_next == 8'd1) begin
                    marked_len_next = consumed_next;
                    marked_next     = 1'b1;
                  end
                  consumed_next   = sat_inc(consumed_next);
                  scan_phase_next = PH_CM_STAR;
                end else if (c > CH_ASCII_MAX) begin
                  fin = 1'b1;
                end else begin
                  marked_len_next = consumed_next;
                  marked_next     = 1'b1;
                  consumed_next   = sat_inc(consumed_next);
                  scan_phase_next = PH_CM_LOOP;
                end
              end
              default: begin
                scan_phase_next = PH_IDLE;
              end
            endcase
          end

          if (fin) scan_phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // Result beat, formed from the updated state
  assign res_fire            = fin;
  assign res.accepted        = fin_ok;
  assign res.token_kind      = fin_ok ? fin_kind : 3'd0;
  assign res.token_length    = fin_ok ? (marked_next ? marked_len_next : consumed_next)
                                      : '0;
  assign res.pound_count_out = stored_pounds_next;

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase     <= PH_IDLE;
      kind_mask      <= '0;
      stored_pounds  <= '0;
      running_pounds <= '0;
      depth          <= '0;
      consumed       <= '0;
      marked_len     <= '0;
      marked         <= 1'b0;
    end else if (step) begin
      scan_phase     <= scan_phase_next;
      kind_mask      <= kind_mask_next;
      stored_pounds  <= stored_pounds_next;
      running_pounds <= running_pounds_next;
      depth          <= depth_next;
      consumed       <= consumed_next;
      marked_len     <= marked_len_next;
      marked         <= marked_next;
    end
  end

  `RSL_ASSERT(a_idle_after_result, clk, rst, step && res_fire |=> scan_phase == PH_IDLE, "scan not closed after result")
  `RSL_ASSERT(a_start_opens, clk, rst, step && item.cmd == CMD_START |=> scan_phase == PH_FIRST && consumed == '0, "start did not open a scan")
  `RSL_ASSERT(a_idle_no_result, clk, rst, scan_phase == PH_IDLE && (item.cmd == CMD_CHAR || item.cmd == CMD_EOF) |-> !res_fire, "result while idle")

endmodule

@@ hdl/raw_string_nested_comment_lexer.sv @@
`timescale 1ns / 1ps
// Raw string / nested block comment lexer, one command beat per cycle while in_ready is high.
// Input channel (in_valid/in_ready): cmd, valid_mask, ch, restore_pounds.
//   cmd start opens a scan with the acceptable kind mask, cmd char feeds one
//   lookahead byte, cmd end-of-input closes the stream, cmd restore loads
//   the kept pound count at any time.
// Output channel (out_valid/out_ready): accepted, token_kind, token_length,
//   pound_count_out; one beat when a scan decides, none otherwise.
// Result: registered, visible the cycle after the deciding input beat.
// Throughput: one input beat per cycle while in_ready is high; the whole
//   per-character update is a single pass of logic between the scan state
//   registers and the output register.
// Stall: while a result waits in the output register and out_ready is
//   low, in_ready drops; taking the result reopens the input in the same
//   cycle, so a steady receiver sees no bubbles.
// Reset (rst, synchronous, active high): scan idle, pound count zero,
//   mask and counters cleared, output register empty.
module raw_string_nested_comment_lexer import rsl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  input  logic [5:0]       valid_mask,
  input  logic [7:0]       ch,
  input  logic [7:0]       restore_pounds,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             accepted,
  output logic [2:0]       token_kind,
  output logic [LEN_W-1:0] token_length,
  output logic [7:0]       pound_count_out
);

  item_t   item;
  result_t res, res_q;
  logic    res_fire, in_fire;

  assign item.cmd            = cmd;
  assign item.valid_mask     = valid_mask;
  assign item.ch             = ch;
  assign item.restore_pounds = restore_pounds;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  rsl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_fire),
    .item     (item),
    .res_fire (res_fire),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) res_q <= res;
  end

  assign accepted        = res_q.accepted;
  assign token_kind      = res_q.token_kind;
  assign token_length    = res_q.token_length;
  assign pound_count_out = res_q.pound_count_out;

  `RSL_ASSERT(a_no_overwrite, clk, rst, out_valid && !out_ready |-> !in_ready, "input open while result stalled")
  `RSL_ASSERT(a_result_lands, clk, rst, in_fire && res_fire |=> out_valid, "result beat lost")
  `RSL_ASSERT(a_reject_clean, clk, rst, out_valid && !accepted |-> token_kind == 3'd0 && token_length == '0, "reject carries kind or length")

endmodule

@@ sim/raw_string_nested_comment_lexer_tb.sv @@
`timescale 1ns / 1ps

module raw_string_nested_comment_lexer_tb;
  import rsl_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PER_PHASE = 140;
  localparam logic [2:0] NO_KIND = 3'd0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       cmd = CMD_START;
  logic [5:0]       valid_mask = '0;
  logic [7:0]       ch = '0;
  logic [7:0]       restore_pounds = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             accepted;
  logic [2:0]       token_kind;
  logic [LEN_W-1:0] token_length;
  logic [7:0]       pound_count_out;

  raw_string_nested_comment_lexer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .valid_mask(valid_mask),
    .ch(ch),
    .restore_pounds(restore_pounds),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .token_kind(token_kind),
    .token_length(token_length),
    .pound_count_out(pound_count_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scanner shadow state
  logic [PHASE_W-1:0] lx_phase = PH_IDLE;
  logic [5:0]         lx_mask = '0;
  logic [7:0]         lx_kept = '0;
  logic [7:0]         lx_run = '0;
  logic [7:0]         lx_depth = '0;
  logic [LEN_W-1:0]   lx_taken = '0;
  logic [LEN_W-1:0]   lx_mark_len = '0;
  logic               lx_marked = 1'b0;

  result_t tok_q[$];
  result_t want;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int unsigned n_items = 0;
  int unsigned fail_cnt = 0;
  int unsigned shown = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void take_char();
    if (lx_taken != MAX_TOKEN_LEN) lx_taken = lx_taken + 1'b1;
  endfunction

  function automatic void set_mark();
    lx_mark_len = lx_taken;
    lx_marked = 1'b1;
  endfunction

  // Scan decided: queue the token the block should emit
  function automatic void close_scan(bit ok, logic [2:0] kind);
    result_t t;
    t.accepted = ok;
    t.token_kind = ok ? kind : NO_KIND;
    t.token_length = ok ? (lx_marked ? lx_mark_len : lx_taken) : '0;
    t.pound_count_out = lx_kept;
    tok_q.push_back(t);
    lx_phase = PH_IDLE;
  endfunction

  // One lookahead byte (or end of input) through the scan phases
  function automatic void scan_byte(logic [7:0] c, bit eof);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lx_phase)
        PH_FIRST: begin
          if (lx_mask[5:3] != 3'b000) begin
            if (eof) close_scan(1'b0, NO_KIND);
            else if (lx_mask[4] && c == CH_BANG) begin
              take_char();
              close_scan(1'b1, KIND_INNERDOC);
            end else if (lx_mask[5] && c == CH_STAR) begin
              take_char();
              set_mark();
              lx_phase = PH_CO_AFTER2;
            end else begin
              take_char();
              lx_depth = 8'd1;
              lx_phase = PH_CM_LOOP;
            end
          end else begin
            // raw paths skip one leading blank
            lx_phase = PH_DISPATCH;
            again = eof || !is_ws(c);
          end
        end
        PH_DISPATCH: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (lx_mask[0] && c == CH_R) begin
            take_char();
            lx_run = '0;
            lx_phase = PH_RS_POUNDS;
          end else if (lx_mask[1]) begin
            lx_phase = PH_RC_SCAN;
            again = 1'b1;
          end else if (lx_mask[2] && c == CH_QUOTE) begin
            take_char();
            lx_run = '0;
            if (lx_kept == 8'd0) close_scan(1'b1, KIND_RAWEND);
            else lx_phase = PH_RE_EAT;
          end else close_scan(1'b0, NO_KIND);
        end
        PH_RS_POUNDS: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (c == CH_POUND) begin
            if (lx_run == MAX_POUNDS) close_scan(1'b0, NO_KIND);
            else begin
              lx_run = lx_run + 1'b1;
              take_char();
            end
          end else if (c == CH_QUOTE) begin
            take_char();
            lx_kept = lx_run;
            close_scan(1'b1, KIND_RAWSTART);
          end else close_scan(1'b0, NO_KIND);
        end
        PH_RC_SCAN: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (c == CH_QUOTE) begin
            set_mark();
            take_char();
            lx_run = '0;
            if (lx_kept == 8'd0) close_scan(1'b1, KIND_RAWCONTENT);
            else lx_phase = PH_RC_CLOSE;
          end else take_char();
        end
        PH_RC_CLOSE: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (lx_run < lx_kept && c == CH_POUND) begin
            lx_run = lx_run + 1'b1;
            take_char();
            if (lx_run == lx_kept) close_scan(1'b1, KIND_RAWCONTENT);
          end else begin
            lx_phase = PH_RC_SCAN;
            again = 1'b1;
          end
        end
        PH_RE_EAT: begin
          // closing pounds are eaten unchecked
          if (eof) close_scan(1'b1, KIND_RAWEND);
          else begin
            take_char();
            lx_run = lx_run + 1'b1;
            if (lx_run >= lx_kept) close_scan(1'b1, KIND_RAWEND);
          end
        end
        PH_CO_AFTER2: begin
          if (!eof && c == CH_SLASH) close_scan(1'b0, NO_KIND);
          else if (!eof && c == CH_STAR) begin
            lx_depth = 8'd1;
            lx_phase = PH_CM_LOOP;
            again = 1'b1;
          end else close_scan(1'b1, KIND_OUTERDOC);
        end
        PH_CM_LOOP: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (c == CH_SLASH) begin
            take_char();
            lx_phase = PH_CM_SLASH;
          end else if (c == CH_STAR) begin
            if (lx_depth == 8'd1) set_mark();
            take_char();
            lx_phase = PH_CM_STAR;
          end else if (c > CH_ASCII_MAX) close_scan(1'b0, NO_KIND);
          else begin
            set_mark();
            take_char();
          end
        end
        PH_CM_SLASH: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (c == CH_STAR && lx_depth >= MAX_DEPTH) close_scan(1'b0, NO_KIND);
          else begin
            if (c == CH_STAR) lx_depth = lx_depth + 1'b1;
            lx_phase = PH_CM_LOOP;
            again = 1'b1;
          end
        end
        PH_CM_STAR: begin
          if (eof) close_scan(1'b0, NO_KIND);
          else if (c == CH_SLASH && lx_depth == 8'd1) begin
            lx_depth = '0;
            close_scan(lx_mask[3], KIND_COMMENT);
          end else begin
            if (c == CH_SLASH && lx_depth != 8'd0) lx_depth = lx_depth - 1'b1;
            lx_phase = PH_CM_LOOP;
            again = 1'b1;
          end
        end
        default: lx_phase = PH_IDLE;
      endcase
    end
  endfunction

  function automatic void lex_step(logic [1:0] c, logic [5:0] m, logic [7:0] b,
                                   logic [7:0] p);
    case (c)
      CMD_START: begin
        lx_mask = m;
        lx_run = '0;
        lx_depth = '0;
        lx_taken = '0;
        lx_mark_len = '0;
        lx_marked = 1'b0;
        lx_phase = PH_FIRST;
      end
      CMD_CHAR: if (lx_phase != PH_IDLE) scan_byte(b, 1'b0);
      CMD_EOF: if (lx_phase != PH_IDLE) scan_byte(8'd0, 1'b1);
      default: lx_kept = p;
    endcase
  endfunction

  // Drive one beat, hold it until taken, then update the shadow scanner
  task automatic send_beat(logic [1:0] c, logic [5:0] m, logic [7:0] b, logic [7:0] p);
    bit gap;
    gap = 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      if (!gap) in_valid <= 1'b0;
      gap = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    valid_mask <= m;
    ch <= b;
    restore_pounds <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!((c == CMD_CHAR || c == CMD_EOF) && lx_phase == PH_IDLE)) n_items++;
    lex_step(c, m, b, p);
  endtask

  task automatic start_scan(logic [5:0] m);
    send_beat(CMD_START, m, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_char(logic [7:0] b);
    if (lx_phase != PH_IDLE)
      send_beat(CMD_CHAR, 6'($urandom_range(63)), b, 8'($urandom_range(255)));
  endtask

  task automatic send_eof();
    if (lx_phase != PH_IDLE)
      send_beat(CMD_EOF, 6'($urandom_range(63)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
  endtask

  task automatic restore(logic [7:0] p);
    send_beat(CMD_RESTORE, 6'($urandom_range(63)), 8'($urandom_range(255)), p);
  endtask

  // Drop valid and wait for every queued token, plus the output latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tok_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] raw_byte();
    case ($urandom_range(5))
      0: return CH_QUOTE;
      1, 2: return CH_POUND;
      3: return CH_R;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] comment_byte();
    case ($urandom_range(19))
      0: return 8'($urandom_range(128, 255));
      1, 2, 3, 4: return CH_SLASH;
      5, 6, 7, 8: return CH_STAR;
      9: return CH_BANG;
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [7:0] pick_pounds();
    return 8'(($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(255));
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(1) == 0) ? 8'd32 : 8'($urandom_range(9, 13));
  endfunction

  // Receiver: random ready, long hold-off on request, result check
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (tok_q.size() == 0) begin
        fail_cnt++;
        if (shown < 10) begin
          shown++;
          $display("unexpected token: acc=%0d kind=%0d len=%0d pounds=%0d",
                   accepted, token_kind, token_length, pound_count_out);
        end
      end else begin
        want = tok_q.pop_front();
        if (accepted !== want.accepted || token_kind !== want.token_kind ||
            token_length !== want.token_length ||
            pound_count_out !== want.pound_count_out) begin
          fail_cnt++;
          if (shown < 10) begin
            shown++;
            $display("token mismatch: exp acc=%0d kind=%0d len=%0d pounds=%0d",
                     want.accepted, want.token_kind, want.token_length,
                     want.pound_count_out);
            $display("                got acc=%0d kind=%0d len=%0d pounds=%0d",
                     accepted, token_kind, token_length, pound_count_out);
          end
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic test_comment_paths();
    start_scan(6'h10); send_char(CH_BANG);
    start_scan(6'h20); send_char(CH_STAR); send_eof();
    start_scan(6'h20); send_char(CH_STAR); send_char(CH_SLASH);
    start_scan(6'h28); send_char(CH_STAR); send_char(8'h41);
    // outer doc falling into a body that closes without the comment bit
    start_scan(6'h20); send_char(CH_STAR); send_char(CH_STAR); send_char(CH_SLASH);
    // nested body
    start_scan(6'h08);
    send_char(8'h61); send_char(CH_SLASH); send_char(CH_STAR); send_char(8'h62);
    send_char(CH_STAR); send_char(CH_SLASH); send_char(8'h20);
    send_char(CH_STAR); send_char(CH_SLASH);
    start_scan(6'h38); send_char(8'h80); send_char(8'hFF);
    start_scan(6'h08); send_eof();
    start_scan(6'h08); send_char(8'h61); send_eof();
    drain();
  endtask

  task automatic test_raw_paths();
    restore(8'd0);
    start_scan(6'h01);
    send_char(8'h20); send_char(CH_R); send_char(CH_POUND); send_char(CH_POUND);
    send_char(CH_QUOTE);
    start_scan(6'h02);
    send_char(8'h61); send_char(CH_QUOTE); send_char(CH_POUND); send_char(8'h78);
    send_char(CH_QUOTE); send_char(CH_POUND); send_char(CH_POUND);
    start_scan(6'h04); send_char(8'h0B); send_char(CH_QUOTE);
    send_char(8'h71); send_char(8'h71);
    start_scan(6'h04); send_char(CH_QUOTE); send_eof();
    restore(8'd0);
    start_scan(6'h06); send_char(CH_QUOTE);
    start_scan(6'h04); send_char(CH_QUOTE);
    start_scan(6'h01); send_char(8'h09); send_char(8'h0D);
    start_scan(6'h00); send_char(8'h78);
    drain();
  endtask

  task automatic test_command_handling();
    // char and end of input while idle are dropped
    send_beat(CMD_CHAR, 6'h3F, CH_QUOTE, 8'hFF);
    send_beat(CMD_EOF, 6'h3F, 8'hFF, 8'hFF);
    // restart abandons the open scan
    start_scan(6'h02); send_char(8'h61); send_char(8'h62);
    start_scan(6'h01); send_char(CH_R); send_char(CH_QUOTE);
    // restore while the closing pounds are being matched
    restore(8'd3);
    start_scan(6'h02); send_char(8'h61); send_char(CH_QUOTE); send_char(CH_POUND);
    restore(8'd1);
    send_char(CH_POUND); send_char(CH_QUOTE); send_char(CH_POUND);
    drain();
  endtask

  task automatic test_overflow_limits();
    // 256th opening pound rejects
    start_scan(6'h01); send_char(CH_R);
    repeat (256) send_char(CH_POUND);
    // 255 pounds are kept, then eaten by the closing delimiter
    start_scan(6'h01); send_char(CH_R);
    repeat (255) send_char(CH_POUND);
    send_char(CH_QUOTE);
    start_scan(6'h04); send_char(CH_QUOTE);
    repeat (255) send_char(8'($urandom_range(255)));
    // nesting one past the deepest level rejects
    start_scan(6'h08); send_char(8'h78);
    repeat (255) begin
      send_char(CH_SLASH); send_char(CH_STAR);
    end
    restore(8'd0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    repeat (12) begin
      start_scan(6'h10);
      send_char(CH_BANG);
    end
    drain();
  endtask

  task automatic random_scan();
    int n;
    logic [5:0] m;
    if ($urandom_range(3) == 0) restore(pick_pounds());
    case ($urandom_range(9))
      0, 1: begin
        m = 6'(1 | ($urandom_range(3) << 1));
        start_scan(m);
        if ($urandom_range(2) == 0) send_char(blank_byte());
        send_char(($urandom_range(9) == 0) ? raw_byte() : CH_R);
        n = ($urandom_range(29) == 0) ? $urandom_range(250, 257) : $urandom_range(4);
        repeat (n) send_char(CH_POUND);
        send_char(($urandom_range(7) == 0) ? raw_byte() : CH_QUOTE);
      end
      2, 3: begin
        m = 6'(2 | ($urandom_range(1) << 2) | ($urandom_range(3) == 0));
        start_scan(m);
        if ($urandom_range(2) == 0) send_char(blank_byte());
        repeat ($urandom_range(12)) send_char(raw_byte());
        send_char(CH_QUOTE);
        n = int'(lx_kept);
        repeat (n) send_char(CH_POUND);
      end
      4: begin
        start_scan(6'(4 | $urandom_range(1)));
        if ($urandom_range(3) == 0) send_char(blank_byte());
        send_char(CH_QUOTE);
        repeat ($urandom_range(6)) send_char(8'($urandom_range(255)));
      end
      5, 6, 7: begin
        m = 6'(($urandom_range(1, 7) << 3) | $urandom_range(7));
        start_scan(m);
        case ($urandom_range(4))
          0: send_char(CH_BANG);
          1: send_char(CH_STAR);
          2: send_char(CH_SLASH);
          default: send_char(comment_byte());
        endcase
        repeat ($urandom_range(10)) send_char(comment_byte());
        repeat (3) begin
          send_char(CH_STAR); send_char(CH_SLASH); send_char(8'h78);
        end
      end
      8: begin
        repeat ($urandom_range(1, 6))
          send_beat(2'($urandom_range(3)), 6'($urandom_range(63)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      default: begin
        start_scan(6'($urandom_range(63)));
        repeat ($urandom_range(3)) send_char(8'($urandom_range(255)));
      end
    endcase
    if ($urandom_range(1) == 0) send_eof();
  endtask

  task automatic run_random_phase(int tx_pct, int rx_pct);
    int unsigned target;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    target = n_items + RAND_PER_PHASE;
    while (n_items < target) random_scan();
    drain();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(50, 0);
    run_random_phase(0, 50);
    run_random_phase(15, 15);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_comment_paths();
    test_raw_paths();
    test_command_handling();
    test_overflow_limits();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && tok_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
